>>> hdl/clns_pkg.sv
package clns_pkg;

  localparam int unsigned CplW  = 6;
  localparam int unsigned LcW   = 3;
  localparam int unsigned StepW = 4;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  localparam logic [2:0] OP_INIT    = 3'd0;
  localparam logic [2:0] OP_RAW     = 3'd1;
  localparam logic [2:0] OP_START   = 3'd2;
  localparam logic [2:0] OP_CHAR    = 3'd3;
  localparam logic [2:0] OP_GOTO    = 3'd4;
  localparam logic [2:0] OP_CURSOR  = 3'd5;
  localparam logic [2:0] OP_DISPLAY = 3'd6;

  localparam logic [1:0] JOB_INIT  = 2'd0;
  localparam logic [1:0] JOB_BYTE  = 2'd1;
  localparam logic [1:0] JOB_BYTE2 = 2'd2;

  localparam logic [StepW-1:0] INIT_LAST  = 4'd11;
  localparam logic [StepW-1:0] BYTE_LAST  = 4'd1;
  localparam logic [StepW-1:0] BYTE2_LAST = 4'd3;

  localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
  localparam logic [7:0] CMD_FUNC_1LINE = 8'h20;
  localparam logic [7:0] CMD_FUNC_2LINE = 8'h28;
  localparam logic [7:0] CMD_DISP_CTRL  = 8'h08;
  localparam logic [7:0] CMD_CURSOR_ON  = 8'h0C;

  localparam logic [CplW-1:0] CPL_RESET = 6'd16;
  localparam logic [LcW-1:0]  LC_RESET  = 3'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic       rs;
    logic [7:0] b0;
    logic [7:0] b1;
  } job_t;

  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] base;
    case (row)
      2'd0: base = 8'h00;
      2'd1: base = 8'h40;
      2'd2: base = 8'h14;
      2'd3: base = 8'h54;
      default: base = 8'h00;
    endcase
    return base;
  endfunction

  function automatic logic [7:0] goto_addr(input logic [5:0] col, input logic [1:0] row);
    return CMD_SET_DDRAM + row_base(row) + {2'b00, col};
  endfunction

  // wake-up nibbles, then function set, entry mode, display on, clear
  function automatic logic [3:0] init_nibble(input logic [StepW-1:0] step,
                                             input logic [7:0] fs);
    logic [3:0] nib;
    case (step)
      4'd0, 4'd1, 4'd2: nib = 4'h3;
      4'd3:  nib = 4'h2;
      4'd4:  nib = fs[7:4];
      4'd5:  nib = fs[3:0];
      4'd6:  nib = 4'h0;
      4'd7:  nib = 4'h6;
      4'd8:  nib = 4'h0;
      4'd9:  nib = 4'hC;
      4'd10: nib = 4'h0;
      4'd11: nib = 4'h1;
      default: nib = 4'h0;
    endcase
    return nib;
  endfunction

endpackage

>>> hdl/clns_front.sv
module clns_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [2:0]                op_i,
  input  logic [7:0]                value_i,
  input  logic [5:0]                column_i,
  input  logic [1:0]                row_i,
  input  logic                      cursor_visible_i,
  input  logic                      cursor_blink_i,
  input  logic                      display_enable_i,
  input  logic [clns_pkg::CplW-1:0] chars_per_line_i,
  input  logic [clns_pkg::LcW-1:0]  line_count_i,
  output logic                      job_valid_o,
  output clns_pkg::job_t            job_o
);
  import clns_pkg::*;

  logic [5:0] char_count_q, char_count_d;
  logic [1:0] line_q, line_d;
  logic       shown_q, shown_d;
  logic       blink_q, blink_d;
  logic [5:0] cnt_inc;
  logic [1:0] line_inc;
  logic [1:0] line_next;

  assign cnt_inc   = char_count_q + 6'd1;
  assign line_inc  = line_q + 2'd1;
  assign line_next = ({1'b0, line_inc} >= line_count_i) ? 2'd0 : line_inc;

  always_comb begin
    char_count_d = char_count_q;
    line_d       = line_q;
    shown_d      = shown_q;
    blink_d      = blink_q;
    job_valid_o  = 1'b1;
    job_o.kind   = JOB_BYTE;
    job_o.rs     = 1'b0;
    job_o.b0     = value_i;
    job_o.b1     = 8'h00;
    case (op_i)
      OP_INIT: begin
        job_o.kind = JOB_INIT;
        job_o.b0   = (line_count_i >= 3'd2) ? CMD_FUNC_2LINE : CMD_FUNC_1LINE;
        shown_d    = 1'b0;
        blink_d    = 1'b0;
      end
      OP_RAW: begin
        job_o.b0 = value_i;
      end
      OP_START: begin
        job_o.b0     = goto_addr(6'd0, 2'd0);
        char_count_d = 6'd0;
        line_d       = 2'd0;
      end
      OP_CHAR: begin
        job_o.rs = 1'b1;
        if (cnt_inc == chars_per_line_i) begin
          job_o.kind   = JOB_BYTE2;
          job_o.b1     = goto_addr(6'd0, line_next);
          char_count_d = 6'd0;
          line_d       = line_next;
        end else begin
          char_count_d = cnt_inc;
        end
      end
      OP_GOTO: begin
        job_o.b0 = goto_addr(column_i, row_i);
      end
      OP_CURSOR: begin
        job_o.b0 = CMD_CURSOR_ON | {6'd0, cursor_visible_i, cursor_blink_i};
        shown_d  = cursor_visible_i;
        blink_d  = cursor_blink_i;
      end
      OP_DISPLAY: begin
        job_o.b0 = CMD_DISP_CTRL | {5'd0, display_enable_i, shown_q, blink_q};
      end
      default: begin
        job_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_count_q <= 6'd0;
      line_q       <= 2'd0;
      shown_q      <= 1'b0;
      blink_q      <= 1'b0;
    end else if (accept_i) begin
      char_count_q <= char_count_d;
      line_q       <= line_d;
      shown_q      <= shown_d;
      blink_q      <= blink_d;
    end
  end

endmodule

>>> hdl/clns_queue.sv
module clns_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  clns_pkg::job_t wdata_i,
  input  logic           rd_i,
  output clns_pkg::job_t rdata_o,
  output logic           empty_o,
  output logic           full_o
);
  import clns_pkg::*;

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QPtrW:0]   count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (QPtrW+1)'(QDepth));
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (wr_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (rd_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (wr_i && !rd_i) begin
        count_q <= count_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> hdl/clns_back.sv
module clns_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_avail_i,
  input  clns_pkg::job_t job_i,
  output logic           job_done_o,
  input  logic           pop_i,
  output logic           out_valid_o,
  output logic           register_select_o,
  output logic [3:0]     nibble_o,
  output logic           last_of_run_o
);
  import clns_pkg::*;

  logic [StepW-1:0] step_q, step_d;
  logic             valid_q, valid_d;
  logic             rs_q, rs_d;
  logic [3:0]       nib_q, nib_d;
  logic             last_q, last_d;
  logic             slot_free;
  logic             advance;
  logic [StepW-1:0] last_step;

  assign slot_free = !valid_q || pop_i;
  assign advance   = job_avail_i && slot_free;

  always_comb begin
    rs_d      = job_i.rs;
    nib_d     = 4'h0;
    last_step = BYTE_LAST;
    case (job_i.kind)
      JOB_INIT: begin
        rs_d      = 1'b0;
        nib_d     = init_nibble(step_q, job_i.b0);
        last_step = INIT_LAST;
      end
      JOB_BYTE: begin
        nib_d     = step_q[0] ? job_i.b0[3:0] : job_i.b0[7:4];
        last_step = BYTE_LAST;
      end
      JOB_BYTE2: begin
        last_step = BYTE2_LAST;
        case (step_q[1:0])
          2'd0: nib_d = job_i.b0[7:4];
          2'd1: nib_d = job_i.b0[3:0];
          2'd2: nib_d = job_i.b1[7:4];
          2'd3: nib_d = job_i.b1[3:0];
          default: nib_d = 4'h0;
        endcase
        if (step_q[1]) begin
          rs_d = 1'b0;
        end
      end
      default: begin
        nib_d = 4'h0;
      end
    endcase
    last_d     = (step_q == last_step);
    job_done_o = advance && last_d;
    step_d     = step_q;
    valid_d    = valid_q && !pop_i;
    if (advance) begin
      valid_d = 1'b1;
      step_d  = last_d ? '0 : step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rs_q   <= rs_d;
      nib_q  <= nib_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o       = valid_q;
  assign register_select_o = rs_q;
  assign nibble_o          = nib_q;
  assign last_of_run_o     = last_q;

endmodule

>>> hdl/char_lcd_nibble_sequencer.sv
// character lcd nibble sequencer, 4-bit bus transfer generator
// request channel: a queue write port (push / full); one word per request
// with op, value, column, row and the cursor and display flags
// transfer channel: a queue read port (empty / pop); each word is one
// transfer: register_select, nibble (d7..d4), last_of_run on a run's end
// config: apb registers chars_per_line at 0x0 and line_count at 0x4, to
// be written only while no request is in flight; the block does not
// enforce this. a front stage updates text position and cursor flags and
// turns each request of a known op into a job; a four-entry job queue
// feeds the back sequencer, which emits one nibble per cycle into an
// output register while a job waits and pop is high or that register is
// empty; a request yields 2 transfers, 4 when text wraps to the next
// line, 12 for init; unknown ops yield none
// when pop stays low the output word holds, the job queue fills and full
// rises; requests are taken again once a job leaves the queue
// reset clears counters, cursor flags, queue pointers and the output
// valid flag and loads chars_per_line = 16, line_count = 2
module char_lcd_nibble_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  op_i,
  input  logic [7:0]  value_i,
  input  logic [5:0]  column_i,
  input  logic [1:0]  row_i,
  input  logic        cursor_visible_i,
  input  logic        cursor_blink_i,
  input  logic        display_enable_i,
  output logic        empty,
  input  logic        pop,
  output logic        register_select_o,
  output logic [3:0]  nibble_o,
  output logic        last_of_run_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import clns_pkg::*;

  logic [CplW-1:0] cpl_q;
  logic [LcW-1:0]  lc_q;
  logic            cfg_wr;
  logic            accept;
  logic            job_valid;
  job_t            job_in;
  job_t            job_head;
  logic            q_empty;
  logic            q_full;
  logic            job_done;
  logic            out_valid;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? {29'd0, lc_q} : {26'd0, cpl_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpl_q <= CPL_RESET;
      lc_q  <= LC_RESET;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        lc_q <= pwdata[LcW-1:0];
      end else begin
        cpl_q <= pwdata[CplW-1:0];
      end
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  clns_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .op_i             (op_i),
    .value_i          (value_i),
    .column_i         (column_i),
    .row_i            (row_i),
    .cursor_visible_i (cursor_visible_i),
    .cursor_blink_i   (cursor_blink_i),
    .display_enable_i (display_enable_i),
    .chars_per_line_i (cpl_q),
    .line_count_i     (lc_q),
    .job_valid_o      (job_valid),
    .job_o            (job_in)
  );

  clns_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (accept && job_valid),
    .wdata_i (job_in),
    .rd_i    (job_done),
    .rdata_o (job_head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  clns_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .job_avail_i       (!q_empty),
    .job_i             (job_head),
    .job_done_o        (job_done),
    .pop_i             (pop),
    .out_valid_o       (out_valid),
    .register_select_o (register_select_o),
    .nibble_o          (nibble_o),
    .last_of_run_o     (last_of_run_o)
  );

  assign empty = !out_valid;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import clns_pkg::*;

  localparam logic [2:0] OP_NONE = 3'd7;
  localparam logic [0:0] REG_CPL = 1'b0;
  localparam logic [0:0] REG_LC = 1'b1;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int END_WAIT = 5000;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic        is_cfg;
    logic [0:0]  cfg_idx;
    logic [5:0]  cfg_val;
    logic [2:0]  op;
    logic [7:0]  value;
    logic [5:0]  column;
    logic [1:0]  row;
    logic        vis;
    logic        blink;
    logic        den;
    logic [3:0]  nfix;
    logic [59:0] fix;
  } stim_t;

  typedef struct packed {
    logic       rs;
    logic [3:0] nib;
    logic       last;
  } xfer_t;

  logic        clk_i, rst_ni;
  logic        push, full, empty, pop;
  logic [2:0]  op_i;
  logic [7:0]  value_i;
  logic [5:0]  column_i;
  logic [1:0]  row_i;
  logic        cursor_visible_i, cursor_blink_i, display_enable_i;
  logic        register_select_o, last_of_run_o;
  logic [3:0]  nibble_o;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  // predictor state
  logic [5:0] cpl_cfg;
  logic [2:0] lc_cfg;
  logic [5:0] chars_done;
  logic [1:0] line_now;
  logic       shown, blinking;

  xfer_t transfers_due[$];
  xfer_t run_q[$];
  stim_t requests_offered[$];

  logic hold_req;
  int   burst_left;
  int   bad_count, requests_taken, transfers_seen;
  int   line_wraps, cfg_writes, cycle_count;

  char_lcd_nibble_sequencer dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .full(full),
    .op_i(op_i), .value_i(value_i), .column_i(column_i), .row_i(row_i),
    .cursor_visible_i(cursor_visible_i), .cursor_blink_i(cursor_blink_i),
    .display_enable_i(display_enable_i),
    .empty(empty), .pop(pop),
    .register_select_o(register_select_o), .nibble_o(nibble_o),
    .last_of_run_o(last_of_run_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void note_bad(input string msg);
    bad_count++;
    if (bad_count <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic logic [7:0] line_base(input logic [1:0] r);
    case (r)
      2'd0: return 8'h00;
      2'd1: return 8'h40;
      2'd2: return 8'h14;
      default: return 8'h54;
    endcase
  endfunction

  function automatic void put_nib(input logic rs, input logic [3:0] nib);
    xfer_t t;
    t.rs = rs;
    t.nib = nib;
    t.last = 1'b0;
    run_q.push_back(t);
  endfunction

  function automatic void put_byte(input logic rs, input logic [7:0] b);
    put_nib(rs, b[7:4]);
    put_nib(rs, b[3:0]);
  endfunction

  function automatic void put_goto(input logic [5:0] col, input logic [1:0] r);
    logic [7:0] addr;
    addr = CMD_SET_DDRAM + line_base(r) + {2'b00, col};
    put_byte(1'b0, addr);
  endfunction

  function automatic void predict_transfers(input stim_t s);
    logic [1:0] next_line;
    xfer_t t;
    int pos;
    run_q.delete();
    case (s.op)
      OP_INIT: begin
        put_nib(1'b0, 4'h3);
        put_nib(1'b0, 4'h3);
        put_nib(1'b0, 4'h3);
        put_nib(1'b0, 4'h2);
        put_byte(1'b0, (lc_cfg >= 3'd2) ? CMD_FUNC_2LINE : CMD_FUNC_1LINE);
        put_byte(1'b0, CMD_ENTRY_MODE);
        put_byte(1'b0, CMD_CURSOR_ON);
        put_byte(1'b0, CMD_CLEAR);
        shown = 1'b0;
        blinking = 1'b0;
      end
      OP_RAW: put_byte(1'b0, s.value);
      OP_START: begin
        put_goto(6'd0, 2'd0);
        chars_done = 6'd0;
        line_now = 2'd0;
      end
      OP_CHAR: begin
        put_byte(1'b1, s.value);
        chars_done = chars_done + 6'd1;
        if (chars_done == cpl_cfg) begin
          next_line = line_now + 2'd1;
          if ({1'b0, next_line} >= lc_cfg) next_line = 2'd0;
          chars_done = 6'd0;
          line_now = next_line;
          line_wraps++;
          put_goto(6'd0, next_line);
        end
      end
      OP_GOTO: put_goto(s.column, s.row);
      OP_CURSOR: begin
        shown = s.vis;
        blinking = s.blink;
        put_byte(1'b0, CMD_CURSOR_ON | {6'b0, s.vis, s.blink});
      end
      OP_DISPLAY: put_byte(1'b0, CMD_DISP_CTRL | {5'b0, s.den, shown, blinking});
      default: ;
    endcase
    // hand-typed expectation replaces the predicted run
    if (s.nfix != 4'd0) begin
      run_q.delete();
      for (int i = 0; i < int'(s.nfix); i++) begin
        pos = (int'(s.nfix) - 1 - i) * 5;
        t = {s.fix[pos +: 5], 1'b0};
        run_q.push_back(t);
      end
    end
    if (run_q.size() > 0) begin
      t = run_q.pop_back();
      t.last = 1'b1;
      run_q.push_back(t);
    end
    foreach (run_q[i]) transfers_due.push_back(run_q[i]);
  endfunction

  always @(posedge clk_i) begin : scoreboard
    xfer_t got, want;
    stim_t s;
    if (rst_ni) begin
      if (pop && !empty) begin
        got = {register_select_o, nibble_o, last_of_run_o};
        transfers_seen++;
        if (transfers_due.size() == 0) begin
          note_bad($sformatf("unexpected word rs=%b nib=%h last=%b",
                             got.rs, got.nib, got.last));
        end else begin
          want = transfers_due.pop_front();
          if (got.rs !== want.rs || got.nib !== want.nib || got.last !== want.last)
            note_bad($sformatf({"word mismatch: expected rs=%b nib=%h last=%b, ",
                                "got rs=%b nib=%h last=%b"},
                               want.rs, want.nib, want.last, got.rs, got.nib, got.last));
        end
      end
      if (push && !full) begin
        s = requests_offered.pop_front();
        requests_taken++;
        predict_transfers(s);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : receiver
    int unsigned mode, span;
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(4, 40);
      for (int k = 0; k < span; k++) begin
        @(posedge clk_i);
        if (hold_req) begin
          pop <= 1'b0;
          for (int c = 1; c < HOLD_CYCLES; c++) @(posedge clk_i);
          hold_req = 1'b0;
        end else begin
          case (mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 1) == 1);
            2: pop <= (k % 3 == 0);
            default: pop <= ($urandom_range(0, 7) == 0);
          endcase
        end
      end
    end
  end

  function automatic stim_t mk_req(input logic [2:0] op, input logic [7:0] value,
                                   input logic [5:0] col, input logic [1:0] row,
                                   input logic [2:0] flags, input logic [3:0] nfix,
                                   input logic [59:0] fix);
    stim_t s;
    s = '0;
    s.op = op;
    s.value = value;
    s.column = col;
    s.row = row;
    {s.vis, s.blink, s.den} = flags;
    s.nfix = nfix;
    s.fix = fix;
    return s;
  endfunction

  function automatic stim_t mk_cfg(input logic [0:0] idx, input logic [5:0] val);
    stim_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.cfg_idx = idx;
    s.cfg_val = val;
    return s;
  endfunction

  function automatic stim_t rand_request();
    stim_t s;
    int pick;
    s = '0;
    s.value = 8'($urandom_range(0, 255));
    s.column = 6'($urandom_range(0, 63));
    s.row = 2'($urandom_range(0, 3));
    s.vis = 1'($urandom_range(0, 1));
    s.blink = 1'($urandom_range(0, 1));
    s.den = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 68) s.op = OP_CHAR;
    else if (pick < 71) s.op = OP_START;
    else if (pick < 79) s.op = OP_GOTO;
    else if (pick < 85) s.op = OP_RAW;
    else if (pick < 90) s.op = OP_CURSOR;
    else if (pick < 95) s.op = OP_DISPLAY;
    else if (pick < 97) s.op = OP_INIT;
    else s.op = OP_NONE;
    return s;
  endfunction

  task automatic send(input stim_t s);
    requests_offered.push_back(s);
    push <= 1'b1;
    op_i <= s.op;
    value_i <= s.value;
    column_i <= s.column;
    row_i <= s.row;
    cursor_visible_i <= s.vis;
    cursor_blink_i <= s.blink;
    display_enable_i <= s.den;
    do @(posedge clk_i); while (full !== 1'b0);
    burst_left--;
    if (burst_left <= 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 10);
    end
  endtask

  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (transfers_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [0:0] idx, input logic [5:0] val);
    logic [31:0] back, mask;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {26'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_CPL) cpl_cfg = val;
    else lc_cfg = val[2:0];
    cfg_writes++;
    // read back
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    back = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    mask = (idx == REG_CPL) ? 32'h3F : 32'h7;
    if ((back & mask) !== ({26'd0, val} & mask))
      note_bad($sformatf("register %0d readback: expected %h, got %h", idx, val, back));
  endtask

  initial begin : stimulus
    stim_t plan[$];
    stim_t s;
    int unsigned p_cpl, p_lc, p_items;
    int w;
    rst_ni = 1'b0;
    push = 1'b0;
    op_i = '0;
    value_i = '0;
    column_i = '0;
    row_i = '0;
    cursor_visible_i = 1'b0;
    cursor_blink_i = 1'b0;
    display_enable_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_req = 1'b0;
    burst_left = 5;
    bad_count = 0;
    requests_taken = 0;
    transfers_seen = 0;
    line_wraps = 0;
    cfg_writes = 0;
    cycle_count = 0;
    cpl_cfg = CPL_RESET;
    lc_cfg = LC_RESET;
    chars_done = '0;
    line_now = '0;
    shown = 1'b0;
    blinking = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    @(posedge clk_i);

    plan.push_back(mk_req(OP_INIT, 8'h00, 6'd0, 2'd0, 3'b000, 4'd12,
                          {5'h03, 5'h03, 5'h03, 5'h02, 5'h02, 5'h08,
                           5'h00, 5'h06, 5'h00, 5'h0C, 5'h00, 5'h01}));
    plan.push_back(mk_req(OP_RAW, 8'h00, 6'd0, 2'd0, 3'b000, 4'd2,
                          60'({5'h00, 5'h00})));
    plan.push_back(mk_req(OP_RAW, 8'hFF, 6'd0, 2'd0, 3'b000, 4'd2,
                          60'({5'h0F, 5'h0F})));
    plan.push_back(mk_req(OP_RAW, 8'hA5, 6'd0, 2'd0, 3'b000, 4'd0, '0));
    plan.push_back(mk_req(OP_CURSOR, 8'h00, 6'd0, 2'd0, 3'b110, 4'd2,
                          60'({5'h00, 5'h0F})));
    plan.push_back(mk_req(OP_DISPLAY, 8'h00, 6'd0, 2'd0, 3'b000, 4'd0, '0));
    plan.push_back(mk_req(OP_DISPLAY, 8'h00, 6'd0, 2'd0, 3'b001, 4'd0, '0));
    plan.push_back(mk_req(OP_CURSOR, 8'h00, 6'd0, 2'd0, 3'b100, 4'd0, '0));
    plan.push_back(mk_req(OP_CURSOR, 8'h00, 6'd0, 2'd0, 3'b010, 4'd0, '0));
    plan.push_back(mk_req(OP_GOTO, 8'h00, 6'd0, 2'd0, 3'b000, 4'd2,
                          60'({5'h08, 5'h00})));
    // address wraps past 0xff
    plan.push_back(mk_req(OP_GOTO, 8'h00, 6'd63, 2'd3, 3'b000, 4'd2,
                          60'({5'h01, 5'h03})));
    plan.push_back(mk_req(OP_GOTO, 8'h00, 6'd21, 2'd1, 3'b000, 4'd0, '0));
    plan.push_back(mk_req(OP_GOTO, 8'h00, 6'd7, 2'd2, 3'b000, 4'd0, '0));
    plan.push_back(mk_req(OP_NONE, 8'hFF, 6'd63, 2'd3, 3'b111, 4'd0, '0));
    plan.push_back(mk_req(OP_START, 8'h00, 6'd0, 2'd0, 3'b000, 4'd0, '0));
    plan.push_back(mk_req(OP_CHAR, 8'h00, 6'd0, 2'd0, 3'b000, 4'd2,
                          60'({5'h10, 5'h10})));
    plan.push_back(mk_req(OP_CHAR, 8'hFF, 6'd0, 2'd0, 3'b000, 4'd2,
                          60'({5'h1F, 5'h1F})));
    plan.push_back(mk_cfg(REG_CPL, 6'd1));
    plan.push_back(mk_cfg(REG_LC, 6'd4));
    plan.push_back(mk_req(OP_START, 8'h00, 6'd0, 2'd0, 3'b000, 4'd0, '0));
    for (int i = 0; i < 4; i++)
      plan.push_back(mk_req(OP_CHAR, 8'h41, 6'd0, 2'd0, 3'b000, 4'd0, '0));
    plan.push_back(mk_cfg(REG_LC, 6'd0));
    plan.push_back(mk_req(OP_CHAR, 8'h5A, 6'd0, 2'd0, 3'b000, 4'd0, '0));
    plan.push_back(mk_cfg(REG_LC, 6'd1));
    plan.push_back(mk_req(OP_INIT, 8'h00, 6'd0, 2'd0, 3'b000, 4'd0, '0));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        reg_write(plan[i].cfg_idx, plan[i].cfg_val);
      end else begin
        send(plan[i]);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin p_cpl = 16; p_lc = 2; p_items = 60; end
        1: begin p_cpl = 40; p_lc = 4; p_items = 100; end
        2: begin p_cpl = 1;  p_lc = 1; p_items = 30; end
        3: begin p_cpl = 0;  p_lc = 0; p_items = 80; end
        4: begin p_cpl = 7;  p_lc = 3; p_items = 40; end
        5: begin p_cpl = 63; p_lc = 7; p_items = 40; end
        6: begin p_cpl = 3;  p_lc = 4; p_items = 40; end
        default: begin p_cpl = 20; p_lc = 2; p_items = 50; end
      endcase
      settle();
      reg_write(REG_CPL, p_cpl[5:0]);
      reg_write(REG_LC, p_lc[5:0]);
      // long output stall while requests keep coming
      if (ph == 1) hold_req = 1'b1;
      send(mk_req(OP_START, 8'h00, 6'd0, 2'd0, 3'b000, 4'd0, '0));
      for (int n = 0; n < p_items; n++) begin
        s = rand_request();
        send(s);
      end
    end

    push <= 1'b0;
    @(posedge clk_i);
    for (w = 0; w < END_WAIT && transfers_due.size() != 0; w++) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (transfers_due.size() != 0)
      note_bad($sformatf("%0d expected words never arrived", transfers_due.size()));

    $display("covered %0d requests, %0d words checked, %0d line wraps, %0d register writes",
             requests_taken, transfers_seen, line_wraps, cfg_writes);
    if (bad_count != 0) $display("%0d mismatches in total", bad_count);
    if (bad_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
